/* rtl/tmsb_pkg.sv */
package tmsb_pkg;

	localparam int SlotCount  = 11;
	localparam int GroupCount = 5;
	localparam int SlotW      = 4;
	localparam int TickW      = 4;
	localparam int CntW       = 4;
	localparam int GroupW     = 3;

	localparam logic [TickW-1:0] TickPeriod = 4'd10;

	// schedule table, one entry per slot
	localparam logic [2:0] SlotDiv [SlotCount] = '{
		3'd1, 3'd1, 3'd1, 3'd5, 3'd5, 3'd2, 3'd2, 3'd5, 3'd2, 3'd2, 3'd2
	};
	localparam logic [TickW-1:0] SlotPhase [SlotCount] = '{
		4'd0, 4'd0, 4'd0, 4'd0, 4'd2, 4'd0, 4'd1, 4'd1, 4'd1, 4'd0, 4'd1
	};

	// watched groups: trigger, mode, switches, keys, buttons
	typedef enum logic [GroupW-1:0] {
		GRP_TRIGGER,
		GRP_MODE,
		GRP_SWITCH,
		GRP_KEYS,
		GRP_BUTTONS
	} grp_t;

	// the one slot that each group forces
	localparam logic [SlotW-1:0] GroupSlot [GroupCount] = '{
		4'd4, 4'd3, 4'd7, 4'd8, 4'd10
	};

	typedef struct packed {
		logic [7:0]  trigger_mode_code;
		logic [7:0]  control_mode_code;
		logic [7:0]  chassis_mode_code;
		logic [15:0] switches;
		logic [15:0] key_bits;
		logic [23:0] buttons;
	} watch_t;

	// tick modulo a divider of 1, 2 or 5, for tick below twice the divider
	function automatic logic [TickW-1:0] tick_mod(input logic [TickW-1:0] tick,
		input logic [2:0] div);
		logic [TickW-1:0] r;
		case (div)
			3'd1: r = '0;
			3'd2: r = {{(TickW-1){1'b0}}, tick[0]};
			3'd5: r = (tick >= 4'd5) ? tick - 4'd5 : tick;
			default: r = tick;
		endcase
		return r;
	endfunction

endpackage

/* rtl/tick_message_scheduler_burst_core.sv */
// When a tick is taken its slots to send (five to ten) are registered in the pending mask,
// and each then moves in turn into the output register whenever that register is empty
// or being taken; the next tick is taken in the cycle its predecessor's last slot moves
// into the output register, so ticks follow back to back while the output does not stall.
// Reset: arst_n clears tick phase, stored values and burst counters, empties the
// queue, and sets the burst count register to 5.
module tick_message_scheduler_burst_core import tmsb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// trigger_mode_code[7:0], control_mode_code[15:8], chassis_mode_code[23:16],
	// switch_left[31:24], switch_right[39:32], key_bits[55:40], button_left[63:56],
	// button_right[71:64], button_middle[79:72], accept_mask[90:80], zero[95:91]
	input  logic [95:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// slot_index[3:0], zero[7:4]
	output logic [7:0]  m_tdata,
	// forced_send[0]
	output logic        m_tuser,
	output logic        m_tlast
);

	logic [CntW-1:0]      burst_cfg_q;
	logic [TickW-1:0]     tick_q;
	watch_t               prev_q;
	logic [CntW-1:0]      cnt_q [GroupCount];

	logic [SlotCount-1:0] pend_mask_q;
	logic [SlotCount-1:0] pend_force_q;

	logic                 out_valid_q;
	logic [SlotW-1:0]     out_slot_q;
	logic                 out_force_q;
	logic                 out_last_q;

	watch_t               cur;
	logic [SlotCount-1:0] accept_mask;
	logic [GroupCount-1:0] chg;
	logic [CntW-1:0]      cnt_ld [GroupCount];
	logic [CntW-1:0]      cnt_nx [GroupCount];
	logic [SlotCount-1:0] due_mask;
	logic [SlotCount-1:0] force_mask;
	logic [SlotCount-1:0] emit_mask;
	logic [TickW-1:0]     tick_inc;
	logic [TickW-1:0]     tick_nx;

	logic                 drain;
	logic [SlotW-1:0]     pick;
	logic [SlotCount-1:0] pend_rest;
	logic                 s_accept;

	assign cur.trigger_mode_code = s_tdata[7:0];
	assign cur.control_mode_code = s_tdata[15:8];
	assign cur.chassis_mode_code = s_tdata[23:16];
	assign cur.switches          = s_tdata[39:24];
	assign cur.key_bits          = s_tdata[55:40];
	assign cur.buttons           = s_tdata[79:56];
	assign accept_mask           = s_tdata[90:80];

	assign chg[GRP_TRIGGER] = cur.trigger_mode_code != prev_q.trigger_mode_code;
	assign chg[GRP_MODE]    = (cur.control_mode_code != prev_q.control_mode_code) ||
	                          (cur.chassis_mode_code != prev_q.chassis_mode_code);
	assign chg[GRP_SWITCH]  = cur.switches != prev_q.switches;
	assign chg[GRP_KEYS]    = cur.key_bits != prev_q.key_bits;
	assign chg[GRP_BUTTONS] = cur.buttons != prev_q.buttons;

	always_comb begin
		for (int i = 0; i < SlotCount; i++) begin
			due_mask[i] = tick_mod(tick_q, SlotDiv[i]) == SlotPhase[i];
		end
		force_mask = '0;
		for (int g = 0; g < GroupCount; g++) begin
			cnt_ld[g] = chg[g] ? burst_cfg_q : cnt_q[g];
			force_mask[GroupSlot[g]] = cnt_ld[g] != '0;
			// a forced slot is always emitted; drop one count when the transmitter takes it
			cnt_nx[g] = cnt_ld[g];
			if (force_mask[GroupSlot[g]] && accept_mask[GroupSlot[g]]) begin
				cnt_nx[g] = cnt_ld[g] - 4'd1;
			end
		end
		emit_mask = due_mask | force_mask;
	end

	assign tick_inc = tick_q + 4'd1;
	assign tick_nx  = (tick_inc >= TickPeriod) ? '0 : tick_inc;

	// lowest pending slot goes out first
	always_comb begin
		pick = '0;
		for (int i = SlotCount - 1; i >= 0; i--) begin
			if (pend_mask_q[i]) begin
				pick = SlotW'(i);
			end
		end
		pend_rest = pend_mask_q;
		pend_rest[pick] = 1'b0;
	end

	assign drain    = (pend_mask_q != '0) && (!out_valid_q || m_tready);
	assign s_tready = (pend_mask_q == '0) || (drain && (pend_rest == '0));
	assign s_accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_cfg_q <= 4'd5;
		end else if (cfg_we) begin
			burst_cfg_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
			prev_q <= '0;
			for (int g = 0; g < GroupCount; g++) begin
				cnt_q[g] <= '0;
			end
		end else if (s_accept) begin
			tick_q <= tick_nx;
			prev_q <= cur;
			for (int g = 0; g < GroupCount; g++) begin
				cnt_q[g] <= cnt_nx[g];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_mask_q  <= '0;
			pend_force_q <= '0;
		end else if (s_accept) begin
			pend_mask_q  <= emit_mask;
			pend_force_q <= force_mask;
		end else if (drain) begin
			pend_mask_q <= pend_rest;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_slot_q  <= '0;
			out_force_q <= 1'b0;
			out_last_q  <= 1'b0;
		end else if (drain) begin
			out_valid_q <= 1'b1;
			out_slot_q  <= pick;
			out_force_q <= pend_force_q[pick];
			out_last_q  <= pend_rest == '0;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0, out_slot_q};
	assign m_tuser  = out_force_q;
	assign m_tlast  = out_last_q;

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;
	import tmsb_pkg::*;

	localparam int NUM_SLOTS  = 11;
	localparam int TICK_WRAP  = 10;
	localparam int NO_GROUP   = 7;
	localparam int IDLE_PCT   = 22;
	localparam int QUIET_MAX  = 3000;
	localparam int ERR_SHOWN  = 10;

	// divider, phase and watched group of each slot
	localparam int SLOT_DIV [NUM_SLOTS] = '{1, 1, 1, 5, 5, 2, 2, 5, 2, 2, 2};
	localparam int SLOT_PH  [NUM_SLOTS] = '{0, 0, 0, 0, 2, 0, 1, 1, 1, 0, 1};
	localparam int SLOT_GRP [NUM_SLOTS] = '{
		NO_GROUP, NO_GROUP, NO_GROUP, GRP_MODE, GRP_TRIGGER, NO_GROUP, NO_GROUP,
		GRP_SWITCH, GRP_KEYS, NO_GROUP, GRP_BUTTONS
	};

	typedef struct packed {
		logic [4:0]  pad;
		logic [10:0] accept;
		logic [7:0]  btn_mid;
		logic [7:0]  btn_right;
		logic [7:0]  btn_left;
		logic [15:0] keys;
		logic [7:0]  sw_right;
		logic [7:0]  sw_left;
		logic [7:0]  chassis;
		logic [7:0]  control;
		logic [7:0]  trigger;
	} tick_word_t;

	typedef struct {
		logic [3:0] slot;
		logic       forced;
		logic       last;
	} slot_send_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [3:0] cfg_wdata = 4'd0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	tick_word_t s_tdata = '0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic       m_tuser;
	logic       m_tlast;

	tick_message_scheduler_burst_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	// scheduler state mirrored on accepted ticks
	logic [3:0]  tick_ph;
	logic [7:0]  seen_trig, seen_ctrl, seen_chas;
	logic [15:0] seen_sw, seen_keys;
	logic [23:0] seen_btn;
	logic [3:0]  burst_left [5];
	logic [3:0]  burst_reload;

	tick_word_t  tick_q [$];
	slot_send_t  sends_q [$];
	slot_send_t  want;
	int          err_cnt = 0;
	int          quiet = 0;
	bit          calm = 1'b0;

	initial begin
		forever #6 clk = ~clk;
	end

	task automatic note_mismatch(input string what);
		err_cnt++;
		if (err_cnt <= ERR_SHOWN)
			$display("%0t: mismatch: %s", $realtime, what);
	endtask

	// schedule one tick: latch changed groups, then walk the slots in order
	task automatic schedule_tick(input tick_word_t w);
		int         n;
		int         g;
		bit         due;
		bit         forced;
		slot_send_t s;
		n = 0;
		if (w.trigger != seen_trig) begin
			seen_trig = w.trigger;
			burst_left[GRP_TRIGGER] = burst_reload;
		end
		if (w.control != seen_ctrl || w.chassis != seen_chas) begin
			seen_ctrl = w.control;
			seen_chas = w.chassis;
			burst_left[GRP_MODE] = burst_reload;
		end
		if ({w.sw_right, w.sw_left} != seen_sw) begin
			seen_sw = {w.sw_right, w.sw_left};
			burst_left[GRP_SWITCH] = burst_reload;
		end
		if (w.keys != seen_keys) begin
			seen_keys = w.keys;
			burst_left[GRP_KEYS] = burst_reload;
		end
		if ({w.btn_mid, w.btn_right, w.btn_left} != seen_btn) begin
			seen_btn = {w.btn_mid, w.btn_right, w.btn_left};
			burst_left[GRP_BUTTONS] = burst_reload;
		end
		for (int i = 0; i < NUM_SLOTS; i++) begin
			g = SLOT_GRP[i];
			due = (int'(tick_ph) % SLOT_DIV[i]) == SLOT_PH[i];
			forced = (g != NO_GROUP) && (burst_left[g] != 4'd0);
			if (due || forced) begin
				s.slot = i[3:0];
				s.forced = forced;
				s.last = 1'b0;
				sends_q.push_back(s);
				n++;
				if (forced && w.accept[i])
					burst_left[g] = burst_left[g] - 4'd1;
			end
		end
		if (n > 0)
			sends_q[sends_q.size()-1].last = 1'b1;
		tick_ph = (tick_ph + 4'd1 >= TICK_WRAP) ? 4'd0 : tick_ph + 4'd1;
	endtask

	// tick driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				schedule_tick(s_tdata);
			if (!s_tvalid || s_tready) begin
				if (tick_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
					s_tvalid <= 1'b1;
					s_tdata <= tick_q.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// slot monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (sends_q.size() == 0) begin
					note_mismatch($sformatf("unexpected slot %0d user %b last %b",
						m_tdata, m_tuser, m_tlast));
				end else begin
					want = sends_q.pop_front();
					if (m_tdata !== {4'd0, want.slot} || m_tuser !== want.forced ||
						m_tlast !== want.last)
						note_mismatch($sformatf(
							"slot exp %0d/%b/%b got %0d/%b/%b (slot/forced/last)",
							want.slot, want.forced, want.last, m_tdata, m_tuser, m_tlast));
				end
			end
			m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// stop if neither side moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet >= QUIET_MAX) begin
				$display("** tick_message_scheduler_burst_core: FAILED **");
				$finish;
			end
		end
	end

	function automatic logic [7:0] pick8();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [10:0] pick_accept();
		case ($urandom_range(9))
			0, 1, 2, 3: return 11'h7FF;
			4: return 11'h000;
			default: return 11'($urandom);
		endcase
	endfunction

	// wait until every tick is taken and every slot has come out
	task automatic drain();
		do @(negedge clk);
		while (tick_q.size() != 0 || s_tvalid || sends_q.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_burst(input logic [3:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		burst_reload = v;
	endtask

	// mostly steady inputs with occasional changes, so bursts run down
	task automatic queue_random(inout tick_word_t cur, input int count);
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(9) == 0) cur.trigger = pick8();
			if ($urandom_range(11) == 0) cur.control = pick8();
			if ($urandom_range(11) == 0) cur.chassis = pick8();
			if ($urandom_range(11) == 0) cur.sw_left = pick8();
			if ($urandom_range(11) == 0) cur.sw_right = pick8();
			if ($urandom_range(9) == 0) cur.keys = {pick8(), pick8()};
			if ($urandom_range(13) == 0) cur.btn_left = pick8();
			if ($urandom_range(13) == 0) cur.btn_right = pick8();
			if ($urandom_range(13) == 0) cur.btn_mid = pick8();
			cur.accept = pick_accept();
			tick_q.push_back(cur);
		end
	endtask

	initial begin
		tick_word_t cur;
		tick_ph = '0;
		seen_trig = '0;
		seen_ctrl = '0;
		seen_chas = '0;
		seen_sw = '0;
		seen_keys = '0;
		seen_btn = '0;
		burst_reload = 4'd5;
		for (int g = 0; g < 5; g++)
			burst_left[g] = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset burst count: no change, then every group changes at once
		cur = '0;
		cur.accept = 11'h7FF;
		tick_q.push_back(cur);
		cur = '1;
		cur.pad = '0;
		cur.accept = 11'h000;
		tick_q.push_back(cur);
		cur.accept = 11'h7FF;
		repeat (5) tick_q.push_back(cur);
		// one group at a time
		cur.trigger = 8'h80;
		cur.accept = 11'h010;
		tick_q.push_back(cur);
		cur.control = 8'h01;
		cur.accept = 11'h000;
		tick_q.push_back(cur);
		cur.chassis = 8'h00;
		cur.accept = 11'h7FF;
		tick_q.push_back(cur);
		cur.sw_left = 8'h00;
		tick_q.push_back(cur);
		cur.sw_right = 8'h7F;
		tick_q.push_back(cur);
		cur.keys = 16'h8000;
		tick_q.push_back(cur);
		cur.btn_mid = 8'h00;
		tick_q.push_back(cur);
		cur.btn_left = 8'h01;
		tick_q.push_back(cur);
		// accept bits only on slots that have no burst
		cur.accept = 11'h267;
		tick_q.push_back(cur);
		drain();

		// zero burst count: changes force nothing
		write_burst(4'd0);
		cur.trigger = 8'h00;
		cur.accept = 11'h7FF;
		tick_q.push_back(cur);
		cur.keys = 16'h0000;
		cur.btn_right = 8'h00;
		tick_q.push_back(cur);
		cur.control = 8'hFF;
		cur.sw_left = 8'hFF;
		tick_q.push_back(cur);
		drain();

		write_burst(4'd15);
		queue_random(cur, 120);
		drain();

		// back-to-back stretch with no idling on either side
		write_burst(4'($urandom_range(14, 1)));
		calm = 1'b1;
		queue_random(cur, 120);
		drain();
		calm = 1'b0;

		write_burst(4'd0);
		queue_random(cur, 60);
		drain();

		write_burst(4'($urandom_range(15)));
		queue_random(cur, 160);
		drain();

		repeat (20) @(posedge clk);
		if (err_cnt == 0)
			$display("** tick_message_scheduler_burst_core: PASSED **");
		else
			$display("** tick_message_scheduler_burst_core: FAILED **");
		$finish;
	end

endmodule
